// ===== src/i2cts_pkg.sv =====
// Shared definitions for the EEPROM/FRAM transfer splitter.
// Holds the controller/datapath interface types, register indexes and part tables.
// No dependencies.
package i2cts_pkg;

    localparam int MAX_REQUEST_LEN = 256;
    localparam int TYPE_SMALL_LAST = 4;
    localparam int TYPE_LARGEST    = 10;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_TYPE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IS_FRAM      = 2'd2;

    localparam logic [3:0] RESET_DEVICE_TYPE  = 4'd1;
    localparam logic [7:0] RESET_BASE_ADDRESS = 8'd160;
    localparam logic       RESET_IS_FRAM      = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic load_desc;
    } t_cmd;

    // Classification of the request held in the datapath.
    typedef struct packed {
        logic empty;
        logic desc_last;
    } t_status;

    // Memory size in bytes; undefined part codes have no capacity.
    function automatic logic [17:0] capacity(input logic [3:0] dev_type);
        logic [17:0] cap;
        if (dev_type <= 4'(TYPE_LARGEST)) begin
            cap = 18'd128 << dev_type;
        end else begin
            cap = 18'd0;
        end
        return cap;
    endfunction

    // Write page size of an EEPROM part.
    function automatic logic [8:0] page_size(input logic [3:0] dev_type);
        logic [8:0] pg;
        case (dev_type)
            4'd0, 4'd1:       pg = 9'd8;
            4'd2, 4'd3, 4'd4: pg = 9'd16;
            4'd5, 4'd6:       pg = 9'd32;
            4'd7, 4'd8:       pg = 9'd64;
            4'd9:             pg = 9'd128;
            default:          pg = 9'd256;
        endcase
        return pg;
    endfunction

endpackage

// ===== src/i2cts_ctrl.sv =====
// Controller state machine of the transfer splitter.
// Sequences request capture, planning and descriptor delivery; uses i2cts_pkg.
module i2cts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  i2cts_pkg::t_status i_status,
    output i2cts_pkg::t_cmd    o_cmd
);
    import i2cts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_SEND
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_fire;
    logic   in_fire;

    assign out_fire    = r_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) ||
                         ((r_state == ST_SEND) && out_fire && i_status.desc_last);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_req  = in_fire;
        o_cmd.load_desc = ((r_state == ST_PLAN) && !i_status.empty) ||
                          ((r_state == ST_SEND) && out_fire && !i_status.desc_last);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                // A zero-length page-split write produces no transaction at all.
                if (i_status.empty) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state     = ST_SEND;
                    n_out_valid = 1'b1;
                end
            end
            ST_SEND: begin
                if (out_fire && i_status.desc_last) begin
                    n_out_valid = 1'b0;
                    n_state     = in_fire ? ST_PLAN : ST_IDLE;
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/i2cts_datapath.sv =====
// Datapath of the transfer splitter: configuration, request registers, chunking
// arithmetic and the descriptor output register. Uses i2cts_pkg.
module i2cts_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [i2cts_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [i2cts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  i2cts_pkg::t_cmd                  i_cmd,
    output i2cts_pkg::t_status               o_status,
    input  logic                             i_mode,
    input  logic [16:0]                      i_start_address,
    input  logic [8:0]                       i_length,
    output logic                             o_error,
    output logic [7:0]                       o_device_address,
    output logic [7:0]                       o_word_address_high,
    output logic [7:0]                       o_word_address_low,
    output logic                             o_two_byte_address,
    output logic                             o_is_read,
    output logic [7:0]                       o_buffer_offset,
    output logic [8:0]                       o_chunk_length,
    output logic                             o_wait_after,
    output logic                             o_last
);
    import i2cts_pkg::*;

    logic [3:0]  r_dev_type;
    logic [7:0]  r_base;
    logic        r_fram;
    logic        r_mode;
    logic [16:0] r_addr;
    logic [8:0]  r_len;
    logic [7:0]  r_off;

    logic        r_error;
    logic [7:0]  r_device_address;
    logic [7:0]  r_word_address_high;
    logic [7:0]  r_word_address_low;
    logic        r_two_byte_address;
    logic        r_is_read;
    logic [7:0]  r_buffer_offset;
    logic [8:0]  r_chunk_length;
    logic        r_wait_after;
    logic        r_last;

    logic [17:0] end_addr;
    logic        err;
    logic        single;
    logic        two;
    logic [8:0]  block;
    logic [8:0]  room;
    logic [8:0]  clen;
    logic [7:0]  dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_type <= RESET_DEVICE_TYPE;
            r_base     <= RESET_BASE_ADDRESS;
            r_fram     <= RESET_IS_FRAM;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DEVICE_TYPE:  r_dev_type <= i_cfg_data[3:0];
                REG_BASE_ADDRESS: r_base     <= i_cfg_data;
                REG_IS_FRAM:      r_fram     <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // The sum of address and remaining length stays fixed while chunks are taken,
    // so the capacity check is still false during a split write.
    assign end_addr = 18'(r_addr) + 18'(r_len);
    assign err      = (32'(r_len) > MAX_REQUEST_LEN) || (end_addr > capacity(r_dev_type));
    assign single   = r_mode || (r_fram && (r_dev_type > 4'(TYPE_SMALL_LAST)));
    assign two      = r_dev_type > 4'(TYPE_SMALL_LAST);

    always_comb begin
        o_status.empty     = !err && !single && (r_len == 9'd0);
        o_status.desc_last = r_last;
    end

    // Pages and FRAM blocks are powers of two, so the offset in a block is a mask.
    assign block = r_fram ? 9'd256 : page_size(r_dev_type);
    assign room  = block - (9'(r_addr[7:0]) & (block - 9'd1));
    assign clen  = (r_len > room) ? room : r_len;

    always_comb begin
        if (two) begin
            dev = r_base;
            if (r_dev_type == 4'(TYPE_LARGEST)) begin
                dev[1] = r_base[1] | r_addr[16];
            end
        end else begin
            dev = r_base | r_addr[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= i_mode;
            r_addr <= i_start_address;
            r_len  <= i_length;
            r_off  <= 8'd0;
        end else if (i_cmd.load_desc && !err && !single) begin
            r_addr <= r_addr + 17'(clen);
            r_len  <= r_len - clen;
            r_off  <= r_off + clen[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_desc) begin
            if (err) begin
                r_error             <= 1'b1;
                r_device_address    <= 8'd0;
                r_word_address_high <= 8'd0;
                r_word_address_low  <= 8'd0;
                r_two_byte_address  <= 1'b0;
                r_is_read           <= 1'b0;
                r_buffer_offset     <= 8'd0;
                r_chunk_length      <= 9'd0;
                r_wait_after        <= 1'b0;
                r_last              <= 1'b1;
            end else begin
                r_error             <= 1'b0;
                r_device_address    <= dev;
                r_word_address_high <= two ? r_addr[15:8] : 8'd0;
                r_word_address_low  <= r_addr[7:0];
                r_two_byte_address  <= two;
                r_is_read           <= r_mode;
                r_buffer_offset     <= r_off;
                r_chunk_length      <= single ? r_len : clen;
                r_wait_after        <= !single && !r_fram;
                r_last              <= single || (r_len <= room);
            end
        end
    end

    assign o_error             = r_error;
    assign o_device_address    = r_device_address;
    assign o_word_address_high = r_word_address_high;
    assign o_word_address_low  = r_word_address_low;
    assign o_two_byte_address  = r_two_byte_address;
    assign o_is_read           = r_is_read;
    assign o_buffer_offset     = r_buffer_offset;
    assign o_chunk_length      = r_chunk_length;
    assign o_wait_after        = r_wait_after;
    assign o_last              = r_last;

endmodule

// ===== src/i2c_eeprom_transfer_splitter_unit.sv =====
// A request accepted into the request registers is planned in ST_PLAN, which loads its first descriptor register.
// Throughput: a planning state, then one descriptor per cycle from the chunk
// register loop while i_out_ready does not stall the output.
// The next request is taken in the cycle the final descriptor is delivered.
// Reset (synchronous, active low) empties the output and restores the
// configuration to part code 1, base address 160, EEPROM.
module i2c_eeprom_transfer_splitter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [i2cts_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [i2cts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [16:0]                       i_start_address,
    input  logic [8:0]                        i_length,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_error,
    output logic [7:0]                        o_device_address,
    output logic [7:0]                        o_word_address_high,
    output logic [7:0]                        o_word_address_low,
    output logic                              o_two_byte_address,
    output logic                              o_is_read,
    output logic [7:0]                        o_buffer_offset,
    output logic [8:0]                        o_chunk_length,
    output logic                              o_wait_after,
    output logic                              o_last
);
    import i2cts_pkg::*;

    t_cmd    cmd;
    t_status status;

    i2cts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    i2cts_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_mode              (i_mode),
        .i_start_address     (i_start_address),
        .i_length            (i_length),
        .o_error             (o_error),
        .o_device_address    (o_device_address),
        .o_word_address_high (o_word_address_high),
        .o_word_address_low  (o_word_address_low),
        .o_two_byte_address  (o_two_byte_address),
        .o_is_read           (o_is_read),
        .o_buffer_offset     (o_buffer_offset),
        .o_chunk_length      (o_chunk_length),
        .o_wait_after        (o_wait_after),
        .o_last              (o_last)
    );

endmodule

// ===== src/i2cts_checker.sv =====
// Port-level checks for the transfer splitter, bound to the top level.
// Depends on i2c_eeprom_transfer_splitter_unit and i2cts_pkg.
module i2cts_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_error,
    input logic                              o_is_read,
    input logic [8:0]                        o_chunk_length,
    input logic                              o_wait_after,
    input logic                              o_last
);
    import i2cts_pkg::*;

    // A stalled transaction keeps its descriptor.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_chunk_length)
            && $stable(o_last))
        else $error("output transaction changed while stalled");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last && (o_chunk_length == 9'd0) && !o_wait_after)
        else $error("error result is not a lone final result");

    // No new request is taken while a split is still in flight.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_out_valid && !o_last) && !(o_out_valid && !i_out_ready))
        else $error("request accepted during an unfinished split");

    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_read |-> o_last && !o_wait_after)
        else $error("read was split or waits");

    a_wait_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wait_after |-> (o_chunk_length != 9'd0) && !o_error)
        else $error("page write chunk is empty");

endmodule

bind i2c_eeprom_transfer_splitter_unit i2cts_checker u_i2cts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_error        (o_error),
    .o_is_read      (o_is_read),
    .o_chunk_length (o_chunk_length),
    .o_wait_after   (o_wait_after),
    .o_last         (o_last)
);
